// ----- rtl/hbd_pkg.sv -----
// shared types, constants and helper functions for the http body dechunker
package hbd_pkg;

    localparam int SIZE_WIDTH  = 32;
    localparam int COUNT_WIDTH = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_HT = 8'h09;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BODY_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONTENT_LENGTH = 2'd1;

    // body framing modes
    localparam logic [1:0] MODE_CONTENT_LENGTH = 2'd0;
    localparam logic [1:0] MODE_CHUNKED        = 2'd1;

    // result status codes
    localparam logic [1:0] ST_RUN      = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_ERROR    = 2'd2;
    localparam logic [1:0] ST_IGNORED  = 2'd3;

    typedef enum logic [10:0] {
        PH_SIZE_START  = 11'b000_0000_0001,
        PH_SIZE_DIGITS = 11'b000_0000_0010,
        PH_SIZE_EXT    = 11'b000_0000_0100,
        PH_DATA        = 11'b000_0000_1000,
        PH_DATA_CR     = 11'b000_0001_0000,
        PH_DATA_LF     = 11'b000_0010_0000,
        PH_TRL_START   = 11'b000_0100_0000,
        PH_TRL_CR      = 11'b000_1000_0000,
        PH_TRL_LINE    = 11'b001_0000_0000,
        PH_DONE        = 11'b010_0000_0000,
        PH_ERROR       = 11'b100_0000_0000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_body;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       payload_valid;
        logic [1:0] status;
    } t_out_item;

    // bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= "0" && c <= "9") begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= "a" && c <= "f") begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= "A" && c <= "F") begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_HT) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

// ----- rtl/http_body_dechunker_core.sv -----
// http message body framer: content-length, chunked and until-close modes
//
//  channel | signals                                   | direction | payload
//  --------+-------------------------------------------+-----------+------------------
//  in      | i_in_valid, o_in_stall, i_in              | input     | data_byte, new_body
//  out     | o_out_valid, i_out_stall, o_out           | output    | out_byte, payload_valid, status
//  cfg     | i_cfg_valid, o_cfg_ready, i_cfg_index/data| input     | body_mode, content_length
//
// one byte per cycle sustained while the output is not stalled; an accepted byte is held in the
// input register, then passes through the parse logic into the result register.
// the parse state advances when a byte moves from the input register to the result register.
// reset (synchronous, active low) empties both registers and clears the parse state.
// a stall on the output holds the result and backs up into o_in_stall once the input
// register is occupied.
module http_body_dechunker_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  hbd_pkg::t_in_item                 i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output hbd_pkg::t_out_item                o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hbd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hbd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic                                r_in_valid;
    hbd_pkg::t_in_item                   r_in;
    logic                                r_out_valid;
    hbd_pkg::t_out_item                  r_out;

    logic [1:0]                          r_body_mode;
    logic [hbd_pkg::COUNT_WIDTH-1:0]     r_content_length;

    hbd_pkg::t_phase                     r_phase;
    logic [hbd_pkg::SIZE_WIDTH-1:0]      r_chunk_rem;
    logic [hbd_pkg::SIZE_WIDTH-1:0]      r_size_acc;
    logic [hbd_pkg::COUNT_WIDTH-1:0]     r_body_count;

    hbd_pkg::t_phase                     n_phase;
    logic [hbd_pkg::SIZE_WIDTH-1:0]      n_chunk_rem;
    logic [hbd_pkg::SIZE_WIDTH-1:0]      n_size_acc;
    logic [hbd_pkg::COUNT_WIDTH-1:0]     n_body_count;
    hbd_pkg::t_out_item                  n_out;

    logic                                w_adv;
    logic                                w_in_take;

    assign w_adv       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_adv;
    assign w_in_take   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    // parse one byte against the current state
    always_comb begin
        hbd_pkg::t_phase                 e_phase;
        logic [hbd_pkg::SIZE_WIDTH-1:0]  e_rem;
        logic [hbd_pkg::SIZE_WIDTH-1:0]  e_acc;
        logic [hbd_pkg::SIZE_WIDTH-1:0]  rem_dec;
        logic [hbd_pkg::COUNT_WIDTH-1:0] e_cnt;
        logic [hbd_pkg::COUNT_WIDTH-1:0] cnt_inc;
        logic [4:0]                      hex;
        logic [7:0]                      c;

        c = r_in.data_byte;
        if (r_in.new_body) begin
            e_phase = hbd_pkg::PH_SIZE_START;
            e_rem   = '0;
            e_acc   = '0;
            e_cnt   = '0;
        end else begin
            e_phase = r_phase;
            e_rem   = r_chunk_rem;
            e_acc   = r_size_acc;
            e_cnt   = r_body_count;
        end
        cnt_inc = (e_cnt == '1) ? e_cnt : e_cnt + 1'b1;
        rem_dec = (e_rem != '0) ? e_rem - 1'b1 : e_rem;
        hex     = hbd_pkg::hex_value(c);

        n_phase      = e_phase;
        n_chunk_rem  = e_rem;
        n_size_acc   = e_acc;
        n_body_count = e_cnt;
        n_out.out_byte      = c;
        n_out.payload_valid = 1'b0;
        n_out.status        = hbd_pkg::ST_RUN;

        if (e_phase == hbd_pkg::PH_DONE || e_phase == hbd_pkg::PH_ERROR) begin
            n_out.status = hbd_pkg::ST_IGNORED;
        end else if (r_body_mode == hbd_pkg::MODE_CONTENT_LENGTH) begin
            if (e_cnt >= r_content_length) begin
                n_phase      = hbd_pkg::PH_DONE;
                n_out.status = hbd_pkg::ST_IGNORED;
            end else begin
                n_out.payload_valid = 1'b1;
                n_body_count        = cnt_inc;
                if (cnt_inc == r_content_length) begin
                    n_phase      = hbd_pkg::PH_DONE;
                    n_out.status = hbd_pkg::ST_COMPLETE;
                end
            end
        end else if (r_body_mode != hbd_pkg::MODE_CHUNKED) begin
            n_out.payload_valid = 1'b1;
            n_body_count        = cnt_inc;
        end else begin
            unique case (e_phase)
                hbd_pkg::PH_SIZE_START, hbd_pkg::PH_SIZE_DIGITS: begin
                    if (c == hbd_pkg::CH_LF) begin
                        if (e_acc == '0) begin
                            n_phase = hbd_pkg::PH_TRL_START;
                        end else begin
                            n_chunk_rem = e_acc;
                            n_phase     = hbd_pkg::PH_DATA;
                        end
                        n_size_acc = '0;
                    end else if (hex[4]) begin
                        // saturate once another digit would overflow
                        if (|e_acc[hbd_pkg::SIZE_WIDTH-1:hbd_pkg::SIZE_WIDTH-4]) begin
                            n_size_acc = '1;
                        end else begin
                            n_size_acc = {e_acc[hbd_pkg::SIZE_WIDTH-5:0], hex[3:0]};
                        end
                        n_phase = hbd_pkg::PH_SIZE_DIGITS;
                    end else if (e_phase == hbd_pkg::PH_SIZE_START && hbd_pkg::is_blank(c)) begin
                        n_phase = e_phase;
                    end else begin
                        n_phase = hbd_pkg::PH_SIZE_EXT;
                    end
                end
                hbd_pkg::PH_SIZE_EXT: begin
                    if (c == hbd_pkg::CH_LF) begin
                        if (e_acc == '0) begin
                            n_phase = hbd_pkg::PH_TRL_START;
                        end else begin
                            n_chunk_rem = e_acc;
                            n_phase     = hbd_pkg::PH_DATA;
                        end
                        n_size_acc = '0;
                    end
                end
                hbd_pkg::PH_DATA: begin
                    n_out.payload_valid = 1'b1;
                    n_body_count        = cnt_inc;
                    n_chunk_rem         = rem_dec;
                    if (rem_dec == '0) begin
                        n_phase = hbd_pkg::PH_DATA_CR;
                    end
                end
                hbd_pkg::PH_DATA_CR: begin
                    if (c == hbd_pkg::CH_CR) begin
                        n_phase = hbd_pkg::PH_DATA_LF;
                    end else begin
                        n_phase      = hbd_pkg::PH_ERROR;
                        n_out.status = hbd_pkg::ST_ERROR;
                    end
                end
                hbd_pkg::PH_DATA_LF: begin
                    if (c == hbd_pkg::CH_LF) begin
                        n_phase    = hbd_pkg::PH_SIZE_START;
                        n_size_acc = '0;
                    end else begin
                        n_phase      = hbd_pkg::PH_ERROR;
                        n_out.status = hbd_pkg::ST_ERROR;
                    end
                end
                hbd_pkg::PH_TRL_START, hbd_pkg::PH_TRL_CR: begin
                    if (c == hbd_pkg::CH_LF) begin
                        n_phase      = hbd_pkg::PH_DONE;
                        n_out.status = hbd_pkg::ST_COMPLETE;
                    end else if (c == hbd_pkg::CH_CR && e_phase == hbd_pkg::PH_TRL_START) begin
                        n_phase = hbd_pkg::PH_TRL_CR;
                    end else begin
                        n_phase = hbd_pkg::PH_TRL_LINE;
                    end
                end
                hbd_pkg::PH_TRL_LINE: begin
                    if (c == hbd_pkg::CH_LF) begin
                        n_phase = hbd_pkg::PH_TRL_START;
                    end
                end
                default: begin
                    n_phase      = hbd_pkg::PH_ERROR;
                    n_out.status = hbd_pkg::ST_ERROR;
                end
            endcase
        end
    end

    // control and parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_body_mode      <= hbd_pkg::MODE_CONTENT_LENGTH;
            r_content_length <= '0;
            r_phase          <= hbd_pkg::PH_SIZE_START;
            r_chunk_rem      <= '0;
            r_size_acc       <= '0;
            r_body_count     <= '0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv) begin
                r_phase      <= n_phase;
                r_chunk_rem  <= n_chunk_rem;
                r_size_acc   <= n_size_acc;
                r_body_count <= n_body_count;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    hbd_pkg::REG_BODY_MODE:      r_body_mode      <= i_cfg_data[1:0];
                    hbd_pkg::REG_CONTENT_LENGTH: r_content_length <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

endmodule
